@@ design/crc8fr_pkg.sv @@
// Package of the CRC-8 frame receiver: widths, reset values, the CRC step
// and the structs that pass between the front end, frame buffer and back end.
// Depends on nothing; every other design file uses it.
package crc8fr_pkg;

    localparam int          FRAME_LEN_DEF = 16;
    localparam int          BYTE_W        = 8;
    localparam int          IDX_W         = 6;
    localparam logic [7:0]  ADDR_RST      = 8'h01;
    localparam logic [7:0]  CRC_POLY      = 8'h07;

    // Write of one body byte into the frame buffer, plus the frame-done push.
    typedef struct packed {
        logic             en;
        logic             bank;
        logic [IDX_W-1:0] idx;
        logic [7:0]       data;
        logic             push;
        logic             push_bank;
    } t_fb_wr;

    // Read of one body byte, plus the release of a drained bank.
    typedef struct packed {
        logic             en;
        logic             bank;
        logic [IDX_W-1:0] idx;
        logic             pop;
    } t_fb_rd;

    // One CRC-8 step over a byte, MSB first, no reflection.
    function automatic logic [7:0] crc8_next(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        c = crc ^ b;
        for (int k = 0; k < 8; k++) begin
            if (c[7]) begin
                c = {c[6:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[6:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

@@ design/crc8fr_ifs.sv @@
// Valid/ready channel interfaces of the CRC-8 frame receiver: received
// bytes, address register writes and frame words. Uses crc8fr_pkg widths.
interface crc8fr_rx_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;
    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface crc8fr_cfg_if;
    logic       valid;
    logic       ready;
    logic [7:0] device_address;
    modport source (output valid, output device_address, input ready);
    modport sink   (input valid, input device_address, output ready);
endinterface

interface crc8fr_out_if;
    logic                          valid;
    logic                          ready;
    logic [7:0]                    frame_byte;
    logic [crc8fr_pkg::IDX_W-1:0]  byte_index;
    logic                          last_byte;
    modport source (output valid, output frame_byte, output byte_index, output last_byte,
                    input ready);
    modport sink   (input valid, input frame_byte, input byte_index, input last_byte,
                    output ready);
endinterface

@@ design/crc8fr_fbuf.sv @@
// Two-bank frame buffer: one memory holding two frame bodies and a full flag
// per bank, which forms a two-entry frame queue. Depends on crc8fr_pkg.
module crc8fr_fbuf #(
    parameter int FRAME_LEN = crc8fr_pkg::FRAME_LEN_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  crc8fr_pkg::t_fb_wr  i_wr,
    input  crc8fr_pkg::t_fb_rd  i_rd,
    output logic [1:0]          o_full,
    output logic [7:0]          o_rdata
);
    localparam int IW    = $clog2(FRAME_LEN - 1);
    localparam int DEPTH = 2 << IW;

    logic [7:0] r_mem [DEPTH];
    logic [7:0] r_rdata;
    logic [1:0] r_full;
    logic [1:0] n_full;
    logic [1:0] push_mask;
    logic [1:0] pop_mask;

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[{i_wr.bank, i_wr.idx[IW-1:0]}] <= i_wr.data;
        end
        if (i_rd.en) begin
            r_rdata <= r_mem[{i_rd.bank, i_rd.idx[IW-1:0]}];
        end
    end

    always_comb begin
        push_mask = 2'b00;
        pop_mask  = 2'b00;
        if (i_wr.push) begin
            push_mask[i_wr.push_bank] = 1'b1;
        end
        if (i_rd.pop) begin
            pop_mask[i_rd.bank] = 1'b1;
        end
        n_full = (r_full | push_mask) & ~pop_mask;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_full <= 2'b00;
        end else begin
            r_full <= n_full;
        end
    end

    assign o_full  = r_full;
    assign o_rdata = r_rdata;

    a_push_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_wr.push |-> !r_full[i_wr.push_bank])
        else $error("frame pushed into a bank that is still full");
    a_pop_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rd.pop |-> r_full[i_rd.bank])
        else $error("bank released that holds no frame");
    a_no_write_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_wr.en |-> !r_full[i_wr.bank])
        else $error("byte written into a bank that is being drained");

endmodule

@@ design/crc8fr_front.sv @@
// Front end: hunts for the address byte, collects the frame body into the
// frame buffer and checks the CRC byte. Depends on crc8fr_pkg and crc8fr_ifs.
module crc8fr_front #(
    parameter int FRAME_LEN = crc8fr_pkg::FRAME_LEN_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    crc8fr_rx_if.sink           i_rx,
    input  logic [7:0]          i_dev_addr,
    input  logic [1:0]          i_full,
    output crc8fr_pkg::t_fb_wr  o_wr
);
    localparam int             FW       = $clog2(FRAME_LEN);
    localparam logic [FW-1:0]  LAST_FILL = FW'(FRAME_LEN - 1);

    logic [FW-1:0] r_fill;
    logic [FW-1:0] n_fill;
    logic [7:0]    r_crc;
    logic [7:0]    n_crc;
    logic          r_wbank;
    logic          n_wbank;
    logic          accept;
    logic          crc_good;
    logic [7:0]    b;

    // At the check byte a new frame may open in the other bank, so that bank
    // must be free as well.
    assign i_rx.ready = !i_full[r_wbank] && !(r_fill == LAST_FILL && i_full[~r_wbank]);
    assign accept     = i_rx.valid && i_rx.ready;
    assign b          = i_rx.rx_byte;
    assign crc_good   = (r_crc == b);

    always_comb begin
        n_fill  = r_fill;
        n_crc   = r_crc;
        n_wbank = r_wbank;
        o_wr    = '0;
        o_wr.data = b;
        if (accept) begin
            if (r_fill == '0) begin
                if (b == i_dev_addr) begin
                    o_wr.en   = 1'b1;
                    o_wr.bank = r_wbank;
                    n_crc     = crc8fr_pkg::crc8_next(8'h00, b);
                    n_fill    = FW'(1);
                end
            end else if (r_fill != LAST_FILL) begin
                o_wr.en   = 1'b1;
                o_wr.bank = r_wbank;
                o_wr.idx  = crc8fr_pkg::IDX_W'(r_fill);
                n_crc     = crc8fr_pkg::crc8_next(r_crc, b);
                n_fill    = r_fill + FW'(1);
            end else begin
                o_wr.push      = crc_good;
                o_wr.push_bank = r_wbank;
                n_wbank        = crc_good ? ~r_wbank : r_wbank;
                n_fill         = '0;
                n_crc          = 8'h00;
                if (b == i_dev_addr) begin
                    o_wr.en   = 1'b1;
                    o_wr.bank = n_wbank;
                    n_crc     = crc8fr_pkg::crc8_next(8'h00, b);
                    n_fill    = FW'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill  <= '0;
            r_crc   <= 8'h00;
            r_wbank <= 1'b0;
        end else begin
            r_fill  <= n_fill;
            r_crc   <= n_crc;
            r_wbank <= n_wbank;
        end
    end

    a_fill_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= LAST_FILL)
        else $error("fill count ran past the frame length");

endmodule

@@ design/crc8fr_back.sv @@
// Back end: drains each good frame from the frame buffer as a run of words
// through an output register. Depends on crc8fr_pkg and crc8fr_ifs.
module crc8fr_back #(
    parameter int FRAME_LEN = crc8fr_pkg::FRAME_LEN_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic [1:0]          i_full,
    input  logic [7:0]          i_rdata,
    output crc8fr_pkg::t_fb_rd  o_rd,
    crc8fr_out_if.source        o_frame
);
    localparam int             IW       = $clog2(FRAME_LEN - 1);
    localparam logic [IW-1:0]  LAST_IDX = IW'(FRAME_LEN - 2);

    typedef enum logic [1:0] {
        BK_IDLE = 2'b01,
        BK_RUN  = 2'b10
    } t_bk_state;

    t_bk_state                     r_state;
    t_bk_state                     n_state;
    logic                          r_rbank;
    logic [IW-1:0]                 r_ridx;
    logic                          r_pend;
    logic [IW-1:0]                 r_pend_idx;
    logic                          r_ovld;
    logic [7:0]                    r_obyte;
    logic [crc8fr_pkg::IDX_W-1:0]  r_oidx;
    logic                          r_olast;
    logic                          load;
    logic                          issue;
    logic                          issue_last;

    // The memory read register doubles as a skid stage: it holds its word
    // until the output register can take it.
    assign load       = r_pend && (!r_ovld || o_frame.ready);
    assign issue      = (r_state == BK_RUN) && (!r_pend || load);
    assign issue_last = issue && (r_ridx == LAST_IDX);

    always_comb begin
        o_rd      = '0;
        o_rd.en   = issue;
        o_rd.bank = r_rbank;
        o_rd.idx  = crc8fr_pkg::IDX_W'(r_ridx);
        o_rd.pop  = issue_last;
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            BK_IDLE: begin
                if (i_full[r_rbank]) begin
                    n_state = BK_RUN;
                end
            end
            BK_RUN: begin
                if (issue_last) begin
                    n_state = BK_IDLE;
                end
            end
            default: n_state = BK_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= BK_IDLE;
            r_rbank <= 1'b0;
            r_ridx  <= '0;
            r_pend  <= 1'b0;
            r_ovld  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (issue) begin
                r_ridx <= issue_last ? '0 : r_ridx + IW'(1);
                if (issue_last) begin
                    r_rbank <= ~r_rbank;
                end
            end
            if (issue) begin
                r_pend <= 1'b1;
            end else if (load) begin
                r_pend <= 1'b0;
            end
            if (load) begin
                r_ovld <= 1'b1;
            end else if (o_frame.ready) begin
                r_ovld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (issue) begin
            r_pend_idx <= r_ridx;
        end
        if (load) begin
            r_obyte <= i_rdata;
            r_oidx  <= crc8fr_pkg::IDX_W'(r_pend_idx);
            r_olast <= (r_pend_idx == LAST_IDX);
        end
    end

    assign o_frame.valid      = r_ovld;
    assign o_frame.frame_byte = r_obyte;
    assign o_frame.byte_index = r_oidx;
    assign o_frame.last_byte  = r_olast;

    a_run_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == BK_RUN) |-> i_full[r_rbank])
        else $error("draining a bank that holds no frame");
    a_last_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovld && r_olast) |-> (r_oidx == crc8fr_pkg::IDX_W'(LAST_IDX)))
        else $error("last flag on a word that is not the final body byte");

endmodule

@@ design/crc8_frame_receiver.sv @@
// Top level of the CRC-8 frame receiver: address register, front end,
// frame buffer and back end. Depends on crc8fr_pkg, crc8fr_ifs and submodules.
//
// Usage: received bytes enter on i_rx, one word per handshake. While hunting
// the block drops every byte that differs from the device address. The
// address byte opens a frame of FRAME_LEN bytes; the CRC-8 (poly 0x07, init
// 0) over the first FRAME_LEN-1 bytes is checked against the final byte.
// A good frame leaves on o_frame as FRAME_LEN-1 words, address first, with
// byte_index counting from 0 and last_byte set on the final body byte. A bad
// frame is dropped. A final byte equal to the address also opens the next
// frame. i_cfg writes the device address (reset value 1) and is always ready.
// The front takes one byte per cycle while i_rx.ready is high; the back drains
// one word per cycle while o_frame is ready, through the frame buffer's single
// read port. o_frame.valid follows a good frame's check byte through the bank
// flag, drain state, read and output registers. Two frame banks form a queue,
// so the front keeps collecting while a frame drains. i_rx.ready drops while
// the bank the front writes into still holds a frame, and the check byte also
// waits until the other bank is free. A stalled o_frame holds its word and
// backs up the drain, and once both banks hold frames it stalls the input as
// well. Reset clears the hunt state, the bank flags and the output valid.
module crc8_frame_receiver #(
    parameter int FRAME_LEN = crc8fr_pkg::FRAME_LEN_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    crc8fr_rx_if.sink     i_rx,
    crc8fr_cfg_if.sink    i_cfg,
    crc8fr_out_if.source  o_frame
);
    logic [7:0]          r_dev_addr;
    crc8fr_pkg::t_fb_wr  fb_wr;
    crc8fr_pkg::t_fb_rd  fb_rd;
    logic [1:0]          fb_full;
    logic [7:0]          fb_rdata;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dev_addr <= crc8fr_pkg::ADDR_RST;
        end else if (i_cfg.valid) begin
            r_dev_addr <= i_cfg.device_address;
        end
    end

    crc8fr_front #(.FRAME_LEN(FRAME_LEN)) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_rx       (i_rx),
        .i_dev_addr (r_dev_addr),
        .i_full     (fb_full),
        .o_wr       (fb_wr)
    );

    crc8fr_fbuf #(.FRAME_LEN(FRAME_LEN)) u_fbuf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (fb_wr),
        .i_rd    (fb_rd),
        .o_full  (fb_full),
        .o_rdata (fb_rdata)
    );

    crc8fr_back #(.FRAME_LEN(FRAME_LEN)) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_full  (fb_full),
        .i_rdata (fb_rdata),
        .o_rd    (fb_rd),
        .o_frame (o_frame)
    );

endmodule

@@ sim/tb_crc8_frame_receiver.sv @@
// Self-checking testbench of crc8_frame_receiver: random and directed byte
// streams in, frame words checked against an internal frame/CRC predictor.
// Depends on crc8fr_pkg, the crc8fr channel interfaces and the design files.
`timescale 1ns / 100ps

module tb_crc8_frame_receiver;

    localparam int FRAME_LEN      = crc8fr_pkg::FRAME_LEN_DEF;
    localparam int IDLE_PCT       = 8;
    localparam int HOLD_CYCLES    = 300;
    localparam int SETTLE_CYCLES  = 24;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int RANDOM_ITEMS   = 120;

    typedef logic [7:0] t_rx_q[$];

    typedef struct packed {
        logic [7:0]                   data;
        logic [crc8fr_pkg::IDX_W-1:0] idx;
        logic                         last;
    } t_frame_word;

    typedef enum {
        FK_GOOD,
        FK_BAD_CRC,
        FK_END_ADDR,
        FK_GOOD_RESTART
    } t_frame_kind;

    logic i_clk;
    logic i_rst_n;

    crc8fr_rx_if  rx_if();
    crc8fr_cfg_if cfg_if();
    crc8fr_out_if out_if();

    crc8_frame_receiver #(
        .FRAME_LEN (FRAME_LEN)
    ) u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_rx    (rx_if),
        .i_cfg   (cfg_if),
        .o_frame (out_if)
    );

    // Predictor state.
    logic [7:0]  addr_model;
    logic [7:0]  body_buf [0:FRAME_LEN-1];
    logic [7:0]  crc_acc;
    int          fill_cnt;
    t_frame_word exp_words[$];

    // Stimulus state.
    t_rx_q       rx_pending;
    logic [7:0]  cur_addr;
    bit          no_idle;
    bit          hold_request;
    bit          hold_done;
    int          hold_left;
    int          error_count;

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // CRC-8 with polynomial 0x07, fed one bit at a time, MSB first.
    function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        logic       fb;
        c = crc;
        for (int k = 7; k >= 0; k--) begin
            fb = c[7] ^ b[k];
            c  = {c[6:0], 1'b0} ^ (fb ? 8'h07 : 8'h00);
        end
        return c;
    endfunction

    task automatic report_error(input string what, input t_frame_word want,
                                input t_frame_word got);
        error_count++;
        if (error_count <= 10) begin
            $display("[%0t] %s: expected byte %02h idx %0d last %0b,",
                     $realtime, what, want.data, want.idx, want.last,
                     " got byte %02h idx %0d last %0b",
                     got.data, got.idx, got.last);
        end
    endtask

    // Advances the frame predictor by one accepted byte.
    task automatic predict_rx(input logic [7:0] b);
        t_frame_word w;
        bit          restart;
        restart = 1'b0;
        if (fill_cnt == 0) begin
            restart = (b == addr_model);
        end else if (fill_cnt < FRAME_LEN - 1) begin
            body_buf[fill_cnt] = b;
            crc_acc            = crc8_step(crc_acc, b);
            fill_cnt++;
        end else begin
            if (crc_acc == b) begin
                for (int i = 0; i < FRAME_LEN - 1; i++) begin
                    w.data = body_buf[i];
                    w.idx  = i[crc8fr_pkg::IDX_W-1:0];
                    w.last = (i == FRAME_LEN - 2);
                    exp_words.push_back(w);
                end
            end
            fill_cnt = 0;
            crc_acc  = 8'h00;
            // The check byte may also be the address of the next frame.
            restart  = (b == addr_model);
        end
        if (restart) begin
            body_buf[0] = b;
            crc_acc     = crc8_step(8'h00, b);
            fill_cnt    = 1;
        end
    endtask

    // Builds one frame. When opened is set, the address byte was already sent
    // as the check byte of the previous frame and is left out here.
    task automatic build_frame(input logic [7:0] addr, input t_frame_kind kind,
                               input bit opened, input int fill,
                               output t_rx_q q, output bit restarts);
        logic [7:0] crc;
        logic [7:0] b;
        logic [7:0] tail;
        q   = {};
        crc = crc8_step(8'h00, addr);
        if (!opened) begin
            q.push_back(addr);
        end
        for (int i = 1; i < FRAME_LEN - 1; i++) begin
            b = (fill < 0) ? 8'($urandom_range(0, 255)) : 8'(fill);
            if (i == FRAME_LEN - 2 && kind == FK_GOOD_RESTART) begin
                // Pick the last body byte so that the CRC equals the address.
                for (int v = 0; v < 256; v++) begin
                    if (crc8_step(crc, 8'(v)) == addr) begin
                        b = 8'(v);
                    end
                end
            end
            q.push_back(b);
            crc = crc8_step(crc, b);
        end
        case (kind)
            FK_BAD_CRC:  tail = crc ^ 8'($urandom_range(1, 255));
            FK_END_ADDR: tail = addr;
            default:     tail = crc;
        endcase
        q.push_back(tail);
        restarts = (tail == addr);
    endtask

    task automatic queue_random(input int n_items);
        t_rx_q       q;
        t_frame_kind kind;
        bit          opened;
        int          counted;
        int          r;
        int          k;
        counted = 0;
        opened  = 1'b0;
        while (counted < n_items) begin
            r = $urandom_range(0, 99);
            if (r >= 82 && r < 92 && !opened) begin
                // Line noise while hunting; mostly dropped by the block.
                k = $urandom_range(1, 4);
                repeat (k) rx_pending.push_back(8'($urandom_range(0, 255)));
            end else if (r >= 92) begin
                // Frame cut short; the following bytes land inside it.
                build_frame(cur_addr, FK_GOOD, opened, -1, q, opened);
                k = $urandom_range(1, q.size() - 1);
                for (int i = 0; i < k; i++) begin
                    rx_pending.push_back(q[i]);
                end
                counted += k;
                opened   = 1'b0;
            end else begin
                if (r < 60)      kind = FK_GOOD;
                else if (r < 70) kind = FK_BAD_CRC;
                else if (r < 76) kind = FK_END_ADDR;
                else             kind = FK_GOOD_RESTART;
                build_frame(cur_addr, kind, opened, -1, q, opened);
                rx_pending = {rx_pending, q};
                counted   += q.size();
            end
        end
    endtask

    task automatic wait_drain();
        while (rx_pending.size() != 0 || exp_words.size() != 0) begin
            @(posedge i_clk);
        end
        // A frame dropped for a bad CRC leaves no word to wait for.
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_address(input logic [7:0] a);
        @(posedge i_clk);
        cfg_if.valid          <= 1'b1;
        cfg_if.device_address <= a;
        do @(posedge i_clk); while (!cfg_if.ready);
        addr_model = a;
        cur_addr   = a;
        cfg_if.valid <= 1'b0;
    endtask

    // Byte driver: offers the oldest pending byte and keeps it until taken.
    always @(posedge i_clk) begin : rx_driver
        bit offer;
        if (!i_rst_n) begin
            rx_if.valid <= 1'b0;
        end else begin
            if (rx_if.valid && rx_if.ready) begin
                predict_rx(rx_if.rx_byte);
                void'(rx_pending.pop_front());
            end
            if (rx_if.valid && !rx_if.ready) begin
                offer = 1'b1;
            end else begin
                offer = (rx_pending.size() != 0) &&
                        (no_idle || $urandom_range(0, 99) >= IDLE_PCT);
            end
            rx_if.valid <= offer;
            if (offer) begin
                rx_if.rx_byte <= rx_pending[0];
            end
        end
    end

    // One long receiver hold-off, so that both frame banks fill up.
    always @(posedge i_clk) begin : hold_ctrl
        if (!i_rst_n) begin
            hold_left <= 0;
            hold_done <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end else if (hold_request && !hold_done) begin
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end
    end

    // Frame word monitor.
    always @(posedge i_clk) begin : frame_monitor
        t_frame_word got;
        t_frame_word want;
        if (!i_rst_n) begin
            out_if.ready <= 1'b0;
        end else begin
            if (out_if.valid && out_if.ready) begin
                got.data = out_if.frame_byte;
                got.idx  = out_if.byte_index;
                got.last = out_if.last_byte;
                if (exp_words.size() == 0) begin
                    report_error("unexpected word", '0, got);
                end else begin
                    want = exp_words.pop_front();
                    if (got.data != want.data || got.idx != want.idx ||
                        got.last != want.last) begin
                        report_error("word mismatch", want, got);
                    end
                end
            end
            out_if.ready <= (hold_left == 0) &&
                            (no_idle || $urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    // Watchdog: counts cycles in which no channel moves a word.
    initial begin : watchdog
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((rx_if.valid && rx_if.ready) || (out_if.valid && out_if.ready) ||
                (cfg_if.valid && cfg_if.ready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
        end
        $display("DONE: errors detected");
        $finish;
    end

    initial begin : stimulus
        t_rx_q q;
        bit    opened;
        t_rx_q split_tail;
        rx_if.valid           = 1'b0;
        rx_if.rx_byte         = 8'h00;
        cfg_if.valid          = 1'b0;
        cfg_if.device_address = 8'h00;
        out_if.ready          = 1'b0;
        i_rst_n               = 1'b0;
        addr_model            = crc8fr_pkg::ADDR_RST;
        cur_addr              = crc8fr_pkg::ADDR_RST;
        crc_acc               = 8'h00;
        fill_cnt              = 0;
        no_idle               = 1'b0;
        hold_request          = 1'b0;
        error_count           = 0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part at the reset address: noise, extreme bodies, a bad
        // CRC, check bytes that reopen a frame, and a frame left half done.
        rx_pending.push_back(8'h00);
        rx_pending.push_back(8'hFF);
        rx_pending.push_back(8'hFE);
        build_frame(cur_addr, FK_GOOD, 1'b0, 8'h00, q, opened);
        rx_pending = {rx_pending, q};
        build_frame(cur_addr, FK_GOOD, opened, 8'hFF, q, opened);
        rx_pending = {rx_pending, q};
        build_frame(cur_addr, FK_BAD_CRC, opened, -1, q, opened);
        rx_pending = {rx_pending, q};
        build_frame(cur_addr, FK_END_ADDR, opened, -1, q, opened);
        rx_pending = {rx_pending, q};
        build_frame(cur_addr, FK_GOOD_RESTART, opened, -1, q, opened);
        rx_pending = {rx_pending, q};
        build_frame(cur_addr, FK_GOOD, opened, -1, q, opened);
        rx_pending = {rx_pending, q};
        build_frame(cur_addr, FK_GOOD, opened, -1, q, opened);
        for (int i = 0; i < q.size(); i++) begin
            if (i < 7) rx_pending.push_back(q[i]);
            else       split_tail.push_back(q[i]);
        end
        wait_drain();

        // The address changes while a frame is open; that frame still
        // completes with the old address as its first word.
        write_address(8'hFF);
        rx_pending = {rx_pending, split_tail};
        hold_request = 1'b1;
        queue_random(RANDOM_ITEMS);
        wait_drain();

        write_address(8'h00);
        no_idle = 1'b1;
        queue_random(RANDOM_ITEMS);
        wait_drain();
        no_idle = 1'b0;

        write_address(8'($urandom_range(0, 255)));
        queue_random(RANDOM_ITEMS);
        wait_drain();

        if (error_count == 0 && exp_words.size() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
